### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the deque design
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define AST_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication with the consequent checked in the cycle after the antecedent
`define AST_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/bdq_pkg.sv
// ---------------------------------------------------------------------------
// bdq_pkg
// types and codes shared by the bounded deque cells and top level
// ---------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int CAP_W  = 5;
    localparam int TOT_W  = 5;

    // command codes of an input word
    localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;

    // cell row operations
    typedef logic [2:0] bdq_op_t;
    localparam bdq_op_t OP_HOLD      = 3'd0;
    localparam bdq_op_t OP_SHIFT_R   = 3'd1;
    localparam bdq_op_t OP_SHIFT_L   = 3'd2;
    localparam bdq_op_t OP_PUSH_BACK = 3'd3;
    localparam bdq_op_t OP_POP_BACK  = 3'd4;

    typedef struct packed {
        bdq_op_t                  op;
        logic signed [WORD_W-1:0] word;
    } bdq_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] value;
    } bdq_in_t;

    typedef struct packed {
        logic                     done_ok;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
        logic                     has_items;
        logic                     is_full;
        logic [TOT_W-1:0]         item_total;
    } bdq_out_t;

endpackage

`default_nettype wire

### design/bounded_double_ended_queue.sv
// ---------------------------------------------------------------------------
// bounded_double_ended_queue
// deque of signed 32-bit words with a settable capacity, built as a row of
// shifting cells
// ---------------------------------------------------------------------------
//
//  channel   signals                          direction  payload
//  --------  -------------------------------  ---------  ----------------------
//  in        in_valid / in_ready / in_data    to block   cmd, value
//  out       out_valid / out_ready / out_data from block result of one command
//  cfg       cfg_we / cfg_data                to block   capacity, no read-back
//
//  for each word, the row of cells updates at the accept edge, and the result
//  is then read from the row and registered in the output register
//  a new word is taken while an earlier result still waits in the output
//  register; in_ready drops only while a word's result waits to be registered
//  a stalled out channel holds the next word's result back, and in_ready
//  stays low until the output register frees up
//  reset empties the row (occupied flags cleared), capacity goes to 16
//
`default_nettype none

`include "assert_macros.svh"

module bounded_double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire bdq_pkg::bdq_in_t                 in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output bdq_pkg::bdq_out_t                     out_data,
    input  wire logic                             cfg_we,
    input  wire logic [bdq_pkg::CAP_W-1:0]        cfg_data
);
    import bdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(DEPTH);

    // capacity register
    logic [CAP_W-1:0] cap_reg;

    // item count and sequencing
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pend_reg;
    logic             pend_next;
    logic             ok_reg;
    logic             ok_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    bdq_out_t         out_data_reg;
    bdq_out_t         out_data_next;

    logic             in_fire;
    logic             load_out;
    logic [LIM_W-1:0] cap_ext;
    logic [LIM_W-1:0] limit;
    logic [LIM_W-1:0] count_ext;
    logic             full;
    logic             empty;
    bdq_op_t          op_sel;
    bdq_ctrl_t        ctrl;

    // row of cells
    logic signed [WORD_W-1:0] cell_word [DEPTH];
    logic [DEPTH-1:0]         cell_occ;
    logic [DEPTH-1:0][WORD_W-1:0] cell_back;
    logic [WORD_W-1:0][DEPTH-1:0] back_col;
    logic [WORD_W-1:0]        back_word;
    logic signed [WORD_W-1:0] front_word;

    assign in_ready = ~pend_reg;
    assign in_fire  = in_valid & in_ready;
    assign load_out = pend_reg & (~out_valid_reg | out_ready);

    // effective capacity, saturated to the row length
    assign cap_ext   = LIM_W'(cap_reg);
    assign limit     = (cap_ext > DEPTH_L) ? DEPTH_L : cap_ext;
    assign count_ext = LIM_W'(count_reg);
    assign full      = count_ext >= limit;
    assign empty     = (count_reg == '0);

    // command decode against the current fill level
    always_comb
    begin
        op_sel     = OP_HOLD;
        ok_next    = 1'b1;
        count_next = count_reg;
        case (in_data.cmd)
            CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    op_sel     = OP_PUSH_BACK;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    op_sel     = OP_SHIFT_R;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    op_sel     = OP_SHIFT_L;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    op_sel     = OP_POP_BACK;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                // no operation and unused codes succeed and change nothing
                op_sel     = OP_HOLD;
                ok_next    = 1'b1;
                count_next = count_reg;
            end
        endcase
    end

    assign ctrl.op   = in_fire ? op_sel : OP_HOLD;
    assign ctrl.word = in_data.value;

    // cell 0 sees the pushed word on its left, always occupied;
    // the last cell sees an empty slot on its right
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [WORD_W-1:0] l_word;
            logic                     l_occ;
            logic signed [WORD_W-1:0] r_word;
            logic                     r_occ;

            if (gi == 0)
            begin : g_head
                assign l_word = in_data.value;
                assign l_occ  = 1'b1;
            end
            else
            begin : g_mid_l
                assign l_word = cell_word[gi-1];
                assign l_occ  = cell_occ[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign r_word = '0;
                assign r_occ  = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_word = cell_word[gi+1];
                assign r_occ  = cell_occ[gi+1];
            end

            bdq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left_word  (l_word),
                .left_occ   (l_occ),
                .right_word (r_word),
                .right_occ  (r_occ),
                .word       (cell_word[gi]),
                .occ        (cell_occ[gi]),
                .back_word  (cell_back[gi])
            );
        end
    endgenerate

    // back word: only the last occupied cell drives its word, the rest give
    // zero, so a per-bit or tree selects it
    generate
        for (genvar gb = 0; gb < WORD_W; gb++)
        begin : g_back_bit
            for (genvar gc = 0; gc < DEPTH; gc++)
            begin : g_back_cell
                assign back_col[gb][gc] = cell_back[gc][gb];
            end
            assign back_word[gb] = |back_col[gb];
        end
    endgenerate

    // front word reads zero when the row is empty
    assign front_word = cell_occ[0] ? cell_word[0] : '0;

    always_comb
    begin
        out_data_next.done_ok     = ok_reg;
        out_data_next.front_value = front_word;
        out_data_next.back_value  = back_word;
        out_data_next.has_items   = ~empty;
        out_data_next.is_full     = full;
        out_data_next.item_total  = TOT_W'(count_reg);
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (in_fire)
        begin
            pend_next = 1'b1;
        end
        else if (load_out)
        begin
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_W'(16);
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (in_fire)
            begin
                count_reg <= count_next;
            end
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ok_reg <= ok_next;
        end
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // occupied flags always form a run from the front cell
    `AST_IMPL(a_occ_thermo, clk, rst_n, 1'b1, (cell_occ & (cell_occ + 1'b1)) == '0)
    // the count tracks the number of occupied cells
    `AST_IMPL(a_count_occ, clk, rst_n, 1'b1, $countones(cell_occ) == int'(count_reg))
    // a result taken while the row is being read leaves no word pending
    `AST_NEXT(a_load_clears, clk, rst_n, load_out, !pend_reg && out_valid_reg)

endmodule

`default_nettype wire

### design/bdq_cell.sv
// ---------------------------------------------------------------------------
// bdq_cell
// one slot of the deque row: word plus occupied flag, fed by its neighbors
// ---------------------------------------------------------------------------
`default_nettype none

module bdq_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bdq_pkg::bdq_ctrl_t                ctrl,
    input  wire logic signed [bdq_pkg::WORD_W-1:0] left_word,
    input  wire logic                              left_occ,
    input  wire logic signed [bdq_pkg::WORD_W-1:0] right_word,
    input  wire logic                              right_occ,
    output logic signed [bdq_pkg::WORD_W-1:0]      word,
    output logic                                   occ,
    output logic signed [bdq_pkg::WORD_W-1:0]      back_word
);
    import bdq_pkg::*;

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;
    logic                     occ_reg;
    logic                     occ_next;
    logic                     is_last;

    // last occupied slot of the row
    assign is_last = occ_reg & ~right_occ;

    always_comb
    begin
        word_next = word_reg;
        occ_next  = occ_reg;
        case (ctrl.op)
            OP_SHIFT_R:
            begin
                word_next = left_word;
                occ_next  = left_occ;
            end
            OP_SHIFT_L:
            begin
                word_next = right_word;
                occ_next  = right_occ;
            end
            OP_PUSH_BACK:
            begin
                if (!occ_reg && left_occ)
                begin
                    word_next = ctrl.word;
                    occ_next  = 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (is_last)
                begin
                    occ_next = 1'b0;
                end
            end
            default:
            begin
                word_next = word_reg;
                occ_next  = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word      = word_reg;
    assign occ       = occ_reg;
    assign back_word = is_last ? word_reg : '0;

endmodule

`default_nettype wire
